// File: src/cfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
// No dependencies; every other file of the block imports this package.
package cfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned SHIFT_W  = 48;
    localparam int unsigned CONC_W   = 32;
    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

    // Frame byte positions: the first byte, check bytes of words 0..2, and the last byte.
    localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
    localparam logic [POS_W-1:0] POS_CHK0  = 4'd2;
    localparam logic [POS_W-1:0] POS_CHK1  = 4'd5;
    localparam logic [POS_W-1:0] POS_CHK2  = 4'd8;
    localparam logic [POS_W-1:0] POS_LAST  = POS_CHK2;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WORD0 = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WORD1 = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_WORD2 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } item_t;

    typedef struct packed {
        logic [CONC_W-1:0]        concentration_raw;
        logic signed [TEMP_W-1:0] temperature_raw;
        logic [STATUS_W-1:0]      frame_status;
    } result_t;

    // MSB-first CRC-8 update of one byte, unrolled to an XOR network.
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_TOP) != '0)
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: src/cfd_in_stage.sv
// Input register of the frame decoder: holds one accepted byte transaction.
// Depends on cfd_pkg.
module cfd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rx_valid,
    output logic           rx_ready,
    input  cfd_pkg::item_t item_in,
    input  logic           fire,
    output logic           stage_valid,
    output cfd_pkg::item_t stage_item
);
    import cfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign rx_ready    = !valid_reg || fire;
    assign load        = rx_valid && rx_ready;
    assign valid_next  = load ? 1'b1 : (fire ? 1'b0 : valid_reg);
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_in;
    end

endmodule

// File: src/cfd_frame_core.sv
// Frame state of the decoder: byte position, per-word CRC, data shift and first error.
// Depends on cfd_pkg.
module cfd_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  cfd_pkg::item_t   item,
    output logic             has_result,
    output cfd_pkg::result_t result
);
    import cfd_pkg::*;

    logic [POS_W-1:0]    pos_reg,   pos_next;
    logic [BYTE_W-1:0]   crc_reg,   crc_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [STATUS_W-1:0] err_reg,   err_next;

    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   crc_base;
    logic [SHIFT_W-1:0]  shift_base;
    logic [STATUS_W-1:0] err_base;
    logic [STATUS_W-1:0] word_code;
    logic                restart;
    logic                is_check;
    logic [SHIFT_W-1:0]  shift_upd;
    logic [STATUS_W-1:0] err_upd;

    // A frame start, or a position past the end, begins a fresh frame.
    assign restart    = item.frame_start || (pos_reg > POS_LAST);
    assign pos        = restart ? POS_FIRST : pos_reg;
    assign crc_base   = restart ? CRC_INIT : crc_reg;
    assign shift_base = restart ? '0 : shift_reg;
    assign err_base   = restart ? STATUS_OK : err_reg;
    assign is_check   = pos inside {POS_CHK0, POS_CHK1, POS_CHK2};

    always_comb
    begin
        case (pos)
            POS_CHK0: word_code = STATUS_WORD0;
            POS_CHK1: word_code = STATUS_WORD1;
            POS_CHK2: word_code = STATUS_WORD2;
            default:  word_code = STATUS_OK;
        endcase
    end

    always_comb
    begin
        if (is_check) begin
            shift_upd = shift_base;
            err_upd   = ((item.rx_byte != crc_base) && (err_base == STATUS_OK))
                        ? word_code : err_base;
        end
        else begin
            shift_upd = {shift_base[SHIFT_W-BYTE_W-1:0], item.rx_byte};
            err_upd   = err_base;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        shift_next = shift_reg;
        err_next   = err_reg;
        if (fire) begin
            if (pos == POS_LAST) begin
                pos_next   = POS_FIRST;
                crc_next   = CRC_INIT;
                shift_next = '0;
                err_next   = STATUS_OK;
            end
            else begin
                pos_next   = pos + 1'b1;
                crc_next   = is_check ? CRC_INIT : crc8_byte(crc_base, item.rx_byte);
                shift_next = shift_upd;
                err_next   = err_upd;
            end
        end
    end

    assign has_result               = (pos == POS_LAST);
    assign result.concentration_raw = shift_upd[SHIFT_W-1:SHIFT_W-CONC_W];
    assign result.temperature_raw   = signed'(shift_upd[TEMP_W-1:0]);
    assign result.frame_status      = err_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= POS_FIRST;
            crc_reg   <= CRC_INIT;
            shift_reg <= '0;
            err_reg   <= STATUS_OK;
        end
        else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            shift_reg <= shift_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: src/cfd_out_reg.sv
// Result register of the frame decoder, drives the result channel.
// Depends on cfd_pkg.
module cfd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cfd_pkg::result_t result_in,
    output logic             out_free,
    output logic             res_valid,
    input  logic             res_ready,
    output cfd_pkg::result_t result_out
);
    import cfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || res_ready;
    assign valid_next = load ? 1'b1 : (res_ready ? 1'b0 : valid_reg);
    assign res_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

endmodule

// File: src/crc8_checked_sensor_frame_decoder_unit.sv
// Sensor frame decoder: 9-byte response in, one checked result per frame out.
// Instantiates cfd_in_stage, cfd_frame_core and cfd_out_reg; depends on cfd_pkg.
//
// The block takes a sensor response one byte transaction at a time on the rx
// channel. A frame is 9 bytes: three big-endian 16-bit words, each followed by
// a CRC-8 byte (poly 0x31, init 0xFF, MSB first, no reflection, no final XOR),
// with the CRC restarted for every word. After the ninth byte one result
// transaction carries concentration_raw (words 0 and 1, high word first),
// temperature_raw (word 2, signed) and frame_status (0 = all good, 1/2/3 = word
// 0/1/2 was the first to fail). The values are only meaningful when the status
// is 0. A byte flagged with frame_start drops any partial frame and is taken
// as byte 0; without it, frames simply follow each other. Rate: one byte per
// clock. A byte is held in the input register while the CRC update and frame
// bookkeeping are done combinationally on it; as the byte that ends a frame
// leaves the input register, its result is loaded into the output register,
// which raises res_valid. The output register lets input continue while a
// result waits; the rx side only stalls when a held input byte needs the
// output register and the result there has not been taken.

module crc8_checked_sensor_frame_decoder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // byte input channel
    input  logic                                 rx_valid,
    output logic                                 rx_ready,
    input  logic [cfd_pkg::BYTE_W-1:0]           rx_byte,
    input  logic                                 frame_start,
    // result channel
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [cfd_pkg::CONC_W-1:0]           concentration_raw,
    output logic signed [cfd_pkg::TEMP_W-1:0]    temperature_raw,
    output logic [cfd_pkg::STATUS_W-1:0]         frame_status
);
    import cfd_pkg::*;

    item_t   item_in;
    item_t   stage_item;
    logic    stage_valid;
    logic    stage_fire;
    logic    has_result;
    logic    out_free;
    result_t core_result;
    result_t out_result;

    assign item_in.rx_byte     = rx_byte;
    assign item_in.frame_start = frame_start;

    // A held byte that ends a frame waits until the result register can take
    // its result; every other byte advances at once.
    assign stage_fire = stage_valid && (!has_result || out_free);

    cfd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .item_in     (item_in),
        .fire        (stage_fire),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    cfd_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (stage_fire),
        .item       (stage_item),
        .has_result (has_result),
        .result     (core_result)
    );

    cfd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (stage_fire && has_result),
        .result_in  (core_result),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result_out (out_result)
    );

    assign concentration_raw = out_result.concentration_raw;
    assign temperature_raw   = out_result.temperature_raw;
    assign frame_status      = out_result.frame_status;

endmodule

// File: src/cfd_checker.sv
// Port-level checks for the sensor frame decoder, bound to the top level.
// Depends on cfd_pkg and crc8_checked_sensor_frame_decoder_unit.
module cfd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rx_valid,
    input logic                              rx_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [cfd_pkg::CONC_W-1:0]        concentration_raw,
    input logic signed [cfd_pkg::TEMP_W-1:0] temperature_raw,
    input logic [cfd_pkg::STATUS_W-1:0]      frame_status
);
    import cfd_pkg::*;

    // A stalled result transaction holds its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(concentration_raw)
            && $stable(temperature_raw) && $stable(frame_status))
        else $error("result changed while stalled");

    // The rx side only backs up while a result waits unclaimed.
    a_rx_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> res_valid && !res_ready)
        else $error("rx stalled without output back-pressure");

    // A rising res_valid must follow an accepted byte transaction.
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("result without a preceding byte");

    // A result leaves only by being taken.
    a_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid) |-> $past(res_ready))
        else $error("result dropped");

endmodule

bind crc8_checked_sensor_frame_decoder_unit cfd_checker u_cfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_valid          (rx_valid),
    .rx_ready          (rx_ready),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .concentration_raw (concentration_raw),
    .temperature_raw   (temperature_raw),
    .frame_status      (frame_status)
);
